// ===== rtl/pcmfc_pkg.sv =====
// Shared constants and G.711 encoder functions for the PCM sample format converter.
`default_nettype none

package pcmfc_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_OUT_FORMAT     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_OUT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIG_ENDIAN_OUT = 2'd2;
  localparam int CfgDataW = 3;

  // Output format codes; reserved codes behave as 8-bit
  localparam logic [2:0] FMT_PCM8  = 3'd0;
  localparam logic [2:0] FMT_PCM16 = 3'd1;
  localparam logic [2:0] FMT_PCM24 = 3'd2;
  localparam logic [2:0] FMT_MULAW = 3'd3;
  localparam logic [2:0] FMT_ALAW  = 3'd4;

  // Byte counts
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  localparam int DefHeadroomBits = 3;

  // Mu-law encode of a saturated 16-bit sample
  function automatic logic [7:0] mulaw_enc(input logic [15:0] pcm);
    logic [13:0] p;
    logic [13:0] mag;
    logic [13:0] v;
    logic [7:0]  mask;
    logic [3:0]  seg;
    logic [3:0]  mant;
    p = pcm[15:2];
    if (p[13]) begin
      mag  = 14'(~p + 14'd1);
      mask = 8'h7F;
    end else begin
      mag  = p;
      mask = 8'hFF;
    end
    if (mag > 14'd8159) mag = 14'd8159;
    v = mag + 14'd33;
    if      (v <= 14'h003F) seg = 4'd0;
    else if (v <= 14'h007F) seg = 4'd1;
    else if (v <= 14'h00FF) seg = 4'd2;
    else if (v <= 14'h01FF) seg = 4'd3;
    else if (v <= 14'h03FF) seg = 4'd4;
    else if (v <= 14'h07FF) seg = 4'd5;
    else if (v <= 14'h0FFF) seg = 4'd6;
    else if (v <= 14'h1FFF) seg = 4'd7;
    else                    seg = 4'd8;
    unique case (seg[2:0])
      3'd0: mant = v[4:1];
      3'd1: mant = v[5:2];
      3'd2: mant = v[6:3];
      3'd3: mant = v[7:4];
      3'd4: mant = v[8:5];
      3'd5: mant = v[9:6];
      3'd6: mant = v[10:7];
      default: mant = v[11:8];
    endcase
    if (seg[3]) return 8'h7F ^ mask;
    return {1'b0, seg[2:0], mant} ^ mask;
  endfunction

  // A-law encode of a saturated 16-bit sample
  function automatic logic [7:0] alaw_enc(input logic [15:0] pcm);
    logic [12:0] p;
    logic [11:0] v;
    logic [7:0]  mask;
    logic [2:0]  seg;
    logic [3:0]  mant;
    p = pcm[15:3];
    if (!p[12]) begin
      mask = 8'hD5;
      v    = p[11:0];
    end else begin
      mask = 8'h55;
      v    = ~p[11:0];
    end
    // magnitude fits in 12 bits, so the top segment is the last one
    if      (v <= 12'h01F) seg = 3'd0;
    else if (v <= 12'h03F) seg = 3'd1;
    else if (v <= 12'h07F) seg = 3'd2;
    else if (v <= 12'h0FF) seg = 3'd3;
    else if (v <= 12'h1FF) seg = 3'd4;
    else if (v <= 12'h3FF) seg = 3'd5;
    else if (v <= 12'h7FF) seg = 3'd6;
    else                   seg = 3'd7;
    unique case (seg)
      3'd0, 3'd1: mant = v[4:1];
      3'd2: mant = v[5:2];
      3'd3: mant = v[6:3];
      3'd4: mant = v[7:4];
      3'd5: mant = v[8:5];
      3'd6: mant = v[9:6];
      default: mant = v[10:7];
    endcase
    return {1'b0, seg, mant} ^ mask;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcm_sample_format_converter.sv =====
// Top level: PCM sample format converter with register slice in and result register out.
// Path: a sample passes the input register and then the result register before out_valid
// rises for its result. Throughput: one transaction per cycle while out_ready stays high;
// the shift, saturate and G.711 encode logic sits in one stage between the two.
// Reset: synchronous active-low rst_n empties both stages and loads the config defaults
// (16-bit, two's complement, little-endian).
`default_nettype none

module pcm_sample_format_converter
  import pcmfc_pkg::*;
#(
  parameter int HEADROOM_BITS = DefHeadroomBits
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // sample input
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [31:0]         in_sample,
  input  wire logic                in_last,
  // converted bytes out
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [7:0]          out_first_byte,
  output      logic [7:0]          out_second_byte,
  output      logic [7:0]          out_third_byte,
  output      logic [1:0]          out_byte_count,
  output      logic                out_last
);

  // Right shifts that drop the guard bits and the unused low bits
  localparam int Sh8  = 24 - HEADROOM_BITS;
  localparam int Sh16 = 16 - HEADROOM_BITS;
  localparam int Sh24 = 8 - HEADROOM_BITS;

  // Configuration registers
  logic [2:0] out_format_r;
  logic       signed_out_r;
  logic       big_endian_out_r;

  // Input stage
  logic        s1_valid_r;
  logic [31:0] s1_sample_r;
  logic        s1_last_r;

  // Result stage
  logic        s2_valid_r;
  logic [7:0]  b0_r, b1_r, b2_r;
  logic [1:0]  cnt_r;
  logic        last_r;

  logic        s2_take;
  logic        s1_take;

  logic [7:0]  b0_nxt, b1_nxt, b2_nxt;
  logic [1:0]  cnt_nxt;

  logic signed [31:0] sh8_w, sh16_w, sh24_w;
  logic [7:0]  sat8_w;
  logic [15:0] sat16_w;
  logic [23:0] sat24_w;
  logic [7:0]  u8_w;
  logic [15:0] u16_w;
  logic [23:0] u24_w;

  // Result stage frees up when it is empty or its transaction leaves this cycle
  assign s2_take  = !s2_valid_r || out_ready;
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_ready = s1_take;

  // Config writes are for the user to make only while idle; the block itself does not guard against traffic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_format_r     <= FMT_PCM16;
      signed_out_r     <= 1'b1;
      big_endian_out_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUT_FORMAT:     out_format_r     <= cfg_data;
        CFG_SIGNED_OUT:     signed_out_r     <= cfg_data[0];
        CFG_BIG_ENDIAN_OUT: big_endian_out_r <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Arithmetic shift to the target width, then saturate
  always_comb begin
    sh8_w  = $signed(s1_sample_r) >>> Sh8;
    sh16_w = $signed(s1_sample_r) >>> Sh16;
    sh24_w = $signed(s1_sample_r) >>> Sh24;

    if (sh8_w > 32'sd127)        sat8_w = 8'h7F;
    else if (sh8_w < -32'sd128)  sat8_w = 8'h80;
    else                         sat8_w = sh8_w[7:0];

    if (sh16_w > 32'sd32767)       sat16_w = 16'h7FFF;
    else if (sh16_w < -32'sd32768) sat16_w = 16'h8000;
    else                           sat16_w = sh16_w[15:0];

    if (sh24_w > 32'sd8388607)       sat24_w = 24'h7FFFFF;
    else if (sh24_w < -32'sd8388608) sat24_w = 24'h800000;
    else                             sat24_w = sh24_w[23:0];

    // Offset binary: flip the top bit of the target width
    u8_w  = sat8_w  ^ {!signed_out_r, 7'd0};
    u16_w = sat16_w ^ {!signed_out_r, 15'd0};
    u24_w = sat24_w ^ {!signed_out_r, 23'd0};
  end

  // Pick bytes and order; unused bytes read as zero
  always_comb begin
    b0_nxt  = 8'd0;
    b1_nxt  = 8'd0;
    b2_nxt  = 8'd0;
    cnt_nxt = CNT_ONE;
    unique case (out_format_r)
      FMT_PCM16: begin
        cnt_nxt = CNT_TWO;
        if (big_endian_out_r) begin
          b0_nxt = u16_w[15:8];
          b1_nxt = u16_w[7:0];
        end else begin
          b0_nxt = u16_w[7:0];
          b1_nxt = u16_w[15:8];
        end
      end
      FMT_PCM24: begin
        cnt_nxt = CNT_THREE;
        b1_nxt  = u24_w[15:8];
        if (big_endian_out_r) begin
          b0_nxt = u24_w[23:16];
          b2_nxt = u24_w[7:0];
        end else begin
          b0_nxt = u24_w[7:0];
          b2_nxt = u24_w[23:16];
        end
      end
      // G.711 ignores sign format and byte order
      FMT_MULAW: b0_nxt = mulaw_enc(sat16_w);
      FMT_ALAW:  b0_nxt = alaw_enc(sat16_w);
      // 8-bit and reserved codes
      default:   b0_nxt = u8_w;
    endcase
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_take) s1_valid_r <= in_valid;
      if (s2_take) s2_valid_r <= s1_valid_r;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
    if (s2_take && s1_valid_r) begin
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
      b2_r   <= b2_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= s1_last_r;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_first_byte  = b0_r;
  assign out_second_byte = b1_r;
  assign out_third_byte  = b2_r;
  assign out_byte_count  = cnt_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ===== rtl/pcmfc_checker.sv =====
// Port-level checker for the PCM sample format converter, bound to the top level.
`default_nettype none

module pcmfc_checker
  import pcmfc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [7:0]          out_first_byte,
  input wire logic [7:0]          out_second_byte,
  input wire logic [7:0]          out_third_byte,
  input wire logic [1:0]          out_byte_count,
  input wire logic                out_last
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_byte)
      && $stable(out_second_byte) && $stable(out_third_byte)
      && $stable(out_byte_count) && $stable(out_last))
    else $error("result changed while stalled");

  // Byte count is always one, two or three
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count == CNT_ONE || out_byte_count == CNT_TWO
      || out_byte_count == CNT_THREE)
    else $error("bad byte count");

  // Bytes beyond the count are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == CNT_THREE || out_third_byte == 8'd0)
      && (out_byte_count == CNT_TWO || out_byte_count == CNT_THREE
          || out_second_byte == 8'd0))
    else $error("unused byte not zero");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_ready && !out_valid)
    else $error("pipeline not empty after reset");

  // Input never stalls while the result stage is empty
  a_no_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

bind pcm_sample_format_converter pcmfc_checker u_pcmfc_checker (.*);

`default_nettype wire

// ===== tb/pcm_sample_format_converter_tb.sv =====
// Self-checking testbench for the PCM sample format converter.
`default_nettype none

module pcm_sample_format_converter_tb;
  import pcmfc_pkg::*;

  localparam int HEADROOM = DefHeadroomBits;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 78;

  // Converted bytes as they leave the block
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       last;
  } conv_t;

  // One directed stimulus line; want is used only when typed is set
  typedef struct packed {
    logic [2:0]  fmt;
    logic        sgn;
    logic        be;
    logic [31:0] sample;
    logic        last;
    logic        typed;
    conv_t       want;
  } dir_row_t;

  // Per-transaction note: a typed-in result overrides the predictor
  typedef struct packed {
    logic  typed;
    conv_t want;
  } typed_note_t;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [31:0]         in_sample = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_first_byte;
  logic [7:0]          out_second_byte;
  logic [7:0]          out_third_byte;
  logic [1:0]          out_byte_count;
  logic                out_last;

  pcm_sample_format_converter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_third_byte  (out_third_byte),
    .out_byte_count  (out_byte_count),
    .out_last        (out_last)
  );

  // Mirror of the configuration registers, starting from the reset values
  logic [2:0] cur_fmt = FMT_PCM16;
  logic       cur_sgn = 1'b1;
  logic       cur_be  = 1'b0;

  conv_t       pending_bytes[$];
  typed_note_t typed_notes[$];
  flow_t       flow_mode = FLOW_FREE;
  int          hold_left = 0;
  int          n_bad = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  int          fmt_seen[8];

  // Directed stimulus: extremes of every format, both signedness and byte
  // orders, reserved format codes, and the G.711 clip points
  dir_row_t dir_tab [25] = '{
    '{FMT_PCM16, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, CNT_TWO, 1'b0}},
    '{FMT_PCM16, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b1, '{8'hFF, 8'h7F, 8'h00, CNT_TWO, 1'b1}},
    '{FMT_PCM16, 1'b1, 1'b0, 32'h8000_0000, 1'b0, 1'b1, '{8'h00, 8'h80, 8'h00, CNT_TWO, 1'b0}},
    '{FMT_PCM16, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{FMT_PCM16, 1'b1, 1'b0, 32'h0FFF_E000, 1'b1, 1'b0, '0},
    '{FMT_PCM16, 1'b1, 1'b0, 32'h1000_0000, 1'b0, 1'b0, '0},
    '{FMT_PCM16, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'h00, CNT_TWO, 1'b0}},
    '{FMT_PCM16, 1'b0, 1'b1, 32'h8000_0000, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, CNT_TWO, 1'b1}},
    '{FMT_PCM24, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'h7F, 8'hFF, 8'hFF, CNT_THREE, 1'b0}},
    '{FMT_PCM24, 1'b1, 1'b1, 32'h8000_0000, 1'b0, 1'b1, '{8'h80, 8'h00, 8'h00, CNT_THREE, 1'b0}},
    '{FMT_PCM24, 1'b0, 1'b0, 32'h8000_0000, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, CNT_THREE, 1'b1}},
    '{FMT_PCM24, 1'b0, 1'b0, 32'h1234_5678, 1'b0, 1'b0, '0},
    '{FMT_PCM8,  1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'h7F, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_PCM8,  1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b1, '{8'h80, 8'h00, 8'h00, CNT_ONE, 1'b1}},
    '{FMT_PCM8,  1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b1, '{8'h80, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_MULAW, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b1, '{8'hFF, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_MULAW, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, '{8'h80, 8'h00, 8'h00, CNT_ONE, 1'b1}},
    '{FMT_MULAW, 1'b1, 1'b0, 32'h8000_0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_MULAW, 1'b1, 1'b0, 32'h0004_2000, 1'b0, 1'b0, '0},
    '{FMT_ALAW,  1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b1, '{8'hD5, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_ALAW,  1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, '{8'hAA, 8'h00, 8'h00, CNT_ONE, 1'b1}},
    '{FMT_ALAW,  1'b1, 1'b0, 32'h8000_0000, 1'b0, 1'b1, '{8'h2A, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{FMT_ALAW,  1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{3'd5,      1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'h7F, 8'h00, 8'h00, CNT_ONE, 1'b0}},
    '{3'd7,      1'b0, 1'b1, 32'h8000_0000, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, CNT_ONE, 1'b1}}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("** pcm_sample_format_converter: FAILED **");
    $finish;
  end

  function automatic int saturate(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // Predict the bytes for one sample under the given register values
  function automatic conv_t convert_sample(logic [2:0] fmt, logic sgn, logic be,
                                           logic [31:0] raw, logic lst);
    conv_t r;
    int    s;
    int    lv;
    int    p;
    int    seg;
    logic [23:0] u;
    logic [7:0]  mask;
    r = '0;
    r.last = lst;
    s = raw;
    case (fmt)
      FMT_PCM16: begin
        lv = saturate(s >>> (16 - HEADROOM), 32767);
        u = 24'(lv & 32'hFFFF);
        if (!sgn) u[15] = ~u[15];
        if (be) begin
          r.b0 = u[15:8];
          r.b1 = u[7:0];
        end else begin
          r.b0 = u[7:0];
          r.b1 = u[15:8];
        end
        r.cnt = CNT_TWO;
      end
      FMT_PCM24: begin
        lv = saturate(s >>> (8 - HEADROOM), 8388607);
        u = 24'(lv);
        if (!sgn) u[23] = ~u[23];
        if (be) begin
          r.b0 = u[23:16];
          r.b2 = u[7:0];
        end else begin
          r.b0 = u[7:0];
          r.b2 = u[23:16];
        end
        r.b1 = u[15:8];
        r.cnt = CNT_THREE;
      end
      FMT_MULAW: begin
        lv = saturate(s >>> (16 - HEADROOM), 32767);
        p = lv >>> 2;
        if (p < 0) begin
          p = -p;
          mask = 8'h7F;
        end else begin
          mask = 8'hFF;
        end
        if (p > 8159) p = 8159;
        p = p + 33;
        seg = 0;
        while (seg < 8 && p > (64 << seg) - 1) seg++;
        if (seg == 8) r.b0 = 8'h7F ^ mask;
        else r.b0 = 8'((seg << 4) | ((p >> (seg + 1)) & 15)) ^ mask;
        r.cnt = CNT_ONE;
      end
      FMT_ALAW: begin
        lv = saturate(s >>> (16 - HEADROOM), 32767);
        p = lv >>> 3;
        if (p >= 0) begin
          mask = 8'hD5;
        end else begin
          mask = 8'h55;
          p = -p - 1;
        end
        seg = 0;
        while (seg < 8 && p > (32 << seg) - 1) seg++;
        if (seg == 8) r.b0 = 8'h7F ^ mask;
        else r.b0 = 8'((seg << 4) | ((p >> ((seg < 2) ? 1 : seg)) & 15)) ^ mask;
        r.cnt = CNT_ONE;
      end
      default: begin
        // 8-bit, and the reserved codes that fall back to it
        lv = saturate(s >>> (24 - HEADROOM), 127);
        r.b0 = 8'(lv);
        if (!sgn) r.b0[7] = ~r.b0[7];
        r.cnt = CNT_ONE;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      n_bad++;
    end
  endtask

  // Scoreboard: check the output transaction first, then log the input one.
  // A sample accepted now passes both pipeline registers, so it cannot leave in the same edge.
  always @(posedge clk) begin
    conv_t       want;
    typed_note_t note;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected output transaction bytes %02h %02h %02h count %0d",
                 $time, out_first_byte, out_second_byte, out_third_byte, out_byte_count);
        n_bad++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_first_byte", want.b0, out_first_byte);
        check_field("out_second_byte", want.b1, out_second_byte);
        check_field("out_third_byte", want.b2, out_third_byte);
        check_field("out_byte_count", want.cnt, out_byte_count);
        check_field("out_last", want.last, out_last);
        n_checked++;
      end
    end
    if (rst_n && in_valid && in_ready === 1'b1) begin
      note = typed_notes.pop_front();
      if (note.typed) pending_bytes.push_back(note.want);
      else pending_bytes.push_back(convert_sample(cur_fmt, cur_sgn, cur_be, in_sample, in_last));
      fmt_seen[cur_fmt]++;
    end
  end

  // Receiver: honor a long hold-off first, else stall per the current flow mode
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        case (flow_mode)
          FLOW_RECV_STALL: out_ready <= ($urandom_range(99) >= 76);
          FLOW_BOTH:       out_ready <= ($urandom_range(99) >= 12);
          default:         out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one sample and hold it until the block takes it; returns on the
  // accepting edge with in_valid still high
  task automatic offer_sample(logic [31:0] sample, logic lst, logic typed, conv_t want);
    int idle_pct;
    int gap;
    typed_notes.push_back('{typed, want});
    idle_pct = (flow_mode == FLOW_SEND_IDLE) ? 76 : (flow_mode == FLOW_BOTH) ? 12 : 0;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    in_last   <= lst;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Drop valid and wait until every expected transaction has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; spare data bits are random
  task automatic program_regs(logic [2:0] fmt, logic sgn, logic be);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUT_FORMAT;
    cfg_data  <= fmt;
    @(posedge clk);
    cfg_index <= CFG_SIGNED_OUT;
    cfg_data  <= {2'($urandom_range(3)), sgn};
    @(posedge clk);
    cfg_index <= CFG_BIG_ENDIAN_OUT;
    cfg_data  <= {2'($urandom_range(3)), be};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fmt = fmt;
    cur_sgn = sgn;
    cur_be  = be;
    n_settings++;
  endtask

  // Spread magnitudes over the whole range, with corners mixed in
  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: begin
        r = (1 << $urandom_range(30)) + $urandom_range(15) - 8;
        return $urandom_range(1) ? r : -r;
      end
      2, 3, 4: return r;
      default: return r >>> $urandom_range(30, 4);
    endcase
  endfunction

  initial begin
    logic [2:0] fmt;
    logic       sgn;
    logic       be;
    foreach (fmt_seen[i]) fmt_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; reprogram only when the row asks for another setting
    foreach (dir_tab[i]) begin
      if (dir_tab[i].fmt != cur_fmt || dir_tab[i].sgn != cur_sgn || dir_tab[i].be != cur_be) begin
        settle();
        program_regs(dir_tab[i].fmt, dir_tab[i].sgn, dir_tab[i].be);
      end
      offer_sample(dir_tab[i].sample, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases: walk every format code first, then random settings,
    // rotating through the flow modes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      fmt = (p < 8) ? 3'(p) : 3'($urandom_range(4));
      sgn = (p < 8) ? 1'(p & 1) : 1'($urandom_range(1));
      be  = (p < 8) ? 1'((p >> 1) & 1) : 1'($urandom_range(1));
      program_regs(fmt, sgn, be);
      flow_mode = flow_t'(p % 4);
      // Hold the receiver off long enough to back the block up into its input
      if (p == 5) hold_left = 150;
      repeat (PHASE_ITEMS)
        offer_sample(pick_sample(), ($urandom_range(7) == 0), 1'b0, '0);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d converted samples over %0d register settings, four flow modes.",
             n_checked, n_settings);
    $display("Samples per format code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3],
             fmt_seen[4], fmt_seen[5], fmt_seen[6], fmt_seen[7]);
    if (n_bad == 0 && pending_bytes.size() == 0) begin
      $display("** pcm_sample_format_converter: PASSED **");
    end else begin
      $display("** pcm_sample_format_converter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
